[design/sha1_pkg.sv]
package sha1_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [4:0][31:0]  t_chain;
    typedef logic [15:0][31:0] t_block;

    typedef struct packed {
        logic start;
        logic reinit;
    } t_core_ctl;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int DIGEST_WORDS = 5;

    localparam t_chain H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

endpackage

[design/sha1_core.sv]
module sha1_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_core_ctl i_ctl,
    input  sha1_pkg::t_block   i_block,
    output sha1_pkg::t_chain   o_chain,
    output logic               o_done
);
    import sha1_pkg::*;

    t_chain      r_h;
    t_word       r_a, r_b, r_c, r_d, r_e;
    t_word       r_w [BLOCK_WORDS];
    logic [6:0]  r_round;
    logic        r_run;
    logic        r_fin;

    t_word w_f;
    t_word w_k;
    t_word w_t;
    t_word w_next;

    always_comb begin
        if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K_0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K_2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K_3;
        end
    end

    assign w_t    = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
    assign w_next = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h     <= H_INIT;
            r_run   <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_round <= '0;
            end else if (r_run) begin
                r_round <= r_round + 7'd1;
                if (r_round == 7'(ROUNDS - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
            if (i_ctl.reinit) begin
                r_h <= H_INIT;
            end else if (r_fin) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                r_w[i] <= i_block[i];
            end
        end else if (r_run) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_t;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= {w_next[30:0], w_next[31]};
        end
    end

    assign o_chain = r_h;
    assign o_done  = r_fin;

endmodule

[design/sha1_hash_engine.sv]
// SHA-1 hash engine.
// Input channel (i_valid / o_stall): one request carries a 32-bit message word,
// left aligned, with its count of valid leading bits (above 32 counts as 32)
// and a last-word flag. Bits are packed into 512-bit blocks.
// Output channel (o_valid / i_stall): after a last word the digest leaves as
// five requests, h0 first; o_digest_last marks h4.
// Words that do not complete a block are taken at one per cycle while o_stall
// is low. A word that completes a block holds o_stall while the block is
// handed over, the single round unit runs the 80 rounds and the chaining add
// is done. After a last word, padding sets the pad bit, writes the bit length
// and compresses each padded block (one or two, plus one more if the word
// itself filled a block), then the digest is shown until the receiver takes it.
// The input rate is set by the one-round-per-cycle compression loop.
// While i_stall is high the current digest word holds. Reset (synchronous,
// active low) empties the block, clears the length and loads the initial
// chaining value; no clearing pass is needed.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [5:0]  i_valid_bits,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    import sha1_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FLUSH = 6'b000010,
        S_BUSY  = 6'b000100,
        S_PAD   = 6'b001000,
        S_LEN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    t_block      r_block, n_block;
    logic [8:0]  r_fill, n_fill;
    t_word       r_spill, n_spill;
    logic [63:0] r_msg_bits, n_msg_bits;
    logic [2:0]  r_idx, n_idx;

    t_core_ctl   w_ctl;
    t_chain      w_chain;
    logic        w_done;

    logic [5:0]  w_n;
    t_word       w_masked;
    t_word       w_hi;
    t_word       w_lo;
    logic [9:0]  w_sum;
    logic [3:0]  w_widx;
    t_word       w_pad_bit;

    sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_block (r_block),
        .o_chain (w_chain),
        .o_done  (w_done)
    );

    assign w_n      = (i_valid_bits > 6'd32) ? 6'd32 : i_valid_bits;
    assign w_masked = i_message_word & ~(32'hFFFFFFFF >> w_n);
    assign {w_hi, w_lo} = {w_masked, 32'h0} >> r_fill[4:0];
    assign w_sum    = {1'b0, r_fill} + {4'd0, w_n};
    assign w_widx   = r_fill[8:5];
    assign w_pad_bit = 32'h80000000 >> r_fill[4:0];

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_block    = r_block;
        n_fill     = r_fill;
        n_spill    = r_spill;
        n_msg_bits = r_msg_bits;
        n_idx      = r_idx;
        w_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    for (int i = 0; i < BLOCK_WORDS; i++) begin
                        if (i == int'(w_widx)) begin
                            n_block[i] = r_block[i] | w_hi;
                        end
                        if (i == int'(w_widx) + 1) begin
                            n_block[i] = r_block[i] | w_lo;
                        end
                    end
                    n_fill     = w_sum[8:0];
                    n_spill    = (w_widx == 4'd15) ? w_lo : '0;
                    n_msg_bits = r_msg_bits + {58'd0, w_n};
                    if (w_sum[9]) begin
                        n_state = S_FLUSH;
                        n_ret   = i_last_word ? S_PAD : S_IDLE;
                    end else if (i_last_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_FLUSH: begin
                w_ctl.start = 1'b1;
                n_block     = '0;
                n_block[0]  = r_spill;
                n_spill     = '0;
                n_state     = S_BUSY;
            end
            S_BUSY: begin
                if (w_done) begin
                    n_state = r_ret;
                end
            end
            S_PAD: begin
                for (int i = 0; i < BLOCK_WORDS; i++) begin
                    if (i == int'(w_widx)) begin
                        n_block[i] = r_block[i] | w_pad_bit;
                    end
                end
                n_fill = '0;
                if (r_fill[8:6] == 3'b111) begin
                    n_ret   = S_LEN;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_block[14] = r_msg_bits[63:32];
                n_block[15] = r_msg_bits[31:0];
                n_ret       = S_OUT;
                n_state     = S_FLUSH;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_idx == 3'(DIGEST_WORDS - 1)) begin
                        n_idx        = '0;
                        w_ctl.reinit = 1'b1;
                        n_msg_bits   = '0;
                        n_state      = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_block    <= '0;
            r_fill     <= '0;
            r_spill    <= '0;
            r_msg_bits <= '0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_block    <= n_block;
            r_fill     <= n_fill;
            r_spill    <= n_spill;
            r_msg_bits <= n_msg_bits;
            r_idx      <= n_idx;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = w_chain[r_idx];
    assign o_digest_last = (r_idx == 3'(DIGEST_WORDS - 1));

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_BUSY)
        else $error("compression finished outside of busy wait");

    a_overflow_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && w_sum[9]) |=> r_state == S_FLUSH)
        else $error("full block not handed to round unit");

    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_digest_last) |=> (r_fill == '0 && r_msg_bits == '0))
        else $error("message state not cleared after digest");

    a_pad_block_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> (r_block[15:1] == '0))
        else $error("block not cleared after hand-over");

endmodule
